>>> src/chacha_keystream_four_blocks_unit_assert.svh
// ---------------------------------------------------------------------------
// chacha keystream unit assertion macros
// shared checks written as one-line macros, clocked on clock, off in reset
// ---------------------------------------------------------------------------
`ifndef CHACHA_KEYSTREAM_FOUR_BLOCKS_UNIT_ASSERT_SVH
`define CHACHA_KEYSTREAM_FOUR_BLOCKS_UNIT_ASSERT_SVH

// condition must hold at every edge outside reset
`define CK4B_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger at one edge requires the consequence at the next edge
`define CK4B_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ck4b_pkg.sv
// ---------------------------------------------------------------------------
// ck4b_pkg
// shared types and constants of the chacha four block keystream unit
// ---------------------------------------------------------------------------
package ck4b_pkg;

   // blocks generated per request and sizes derived from it
   localparam int BLOCKS_PER_REQUEST = 4;
   localparam int WORDS_PER_BLOCK    = 16;
   localparam int BLK_W              = (BLOCKS_PER_REQUEST > 1) ?
                                       $clog2(BLOCKS_PER_REQUEST) : 1;
   localparam int WORD_W             = 4;
   localparam int INDEX_W            = 6;

   localparam logic [BLK_W-1:0]   BLK_LAST   = BLK_W'(BLOCKS_PER_REQUEST - 1);
   localparam logic [WORD_W-1:0]  WORD_LAST  = WORD_W'(WORDS_PER_BLOCK - 1);
   localparam logic [INDEX_W-1:0] INDEX_LAST =
      INDEX_W'(BLOCKS_PER_REQUEST * WORDS_PER_BLOCK - 1);

   // quarter round is four add-xor-rotate lines, one per cycle
   localparam logic [1:0] STEP_LAST    = 2'd3;
   localparam logic [2:0] QR_COL_LAST  = 3'd3;
   localparam logic [2:0] QR_DIAG_LAST = 3'd7;

   localparam logic [4:0] ROUND_COUNT_RESET = 5'd20;

   // commands
   localparam logic CMD_GEN  = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_SIGMA_LOW   = 3'd0,
      REG_SIGMA_HIGH  = 3'd1,
      REG_KEY_PART_A  = 3'd2,
      REG_KEY_PART_B  = 3'd3,
      REG_KEY_PART_C  = 3'd4,
      REG_KEY_PART_D  = 3'd5,
      REG_NONCE_WORDS = 3'd6,
      REG_ROUND_COUNT = 3'd7
   } ck4b_reg_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND,
      ST_OUT
   } ck4b_state_type;

   typedef logic [31:0] ck4b_word_type;
   typedef logic [WORDS_PER_BLOCK-1:0][31:0] ck4b_words_type;

   // sequencer to working words
   typedef struct packed {
      logic       load;
      logic       round;
      logic       shift;
      logic [1:0] step;
      logic       diag;
      logic       undiag;
   } ck4b_ctrl_type;

   // sequencer status to top level
   typedef struct packed {
      logic              ready;
      logic              emit;
      logic              last;
      logic [BLK_W-1:0]  blk;
      logic [WORD_W-1:0] word;
   } ck4b_stat_type;

endpackage

>>> src/ck4b_if.sv
// ---------------------------------------------------------------------------
// ck4b channel interfaces
// valid/ready channels for request items and keystream result items
// ---------------------------------------------------------------------------

// request channel: command and block counter for load
interface ck4b_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [63:0] counter_value;

   modport source (output valid, output command, output counter_value, input ready);
   modport sink   (input valid, input command, input counter_value, output ready);
endinterface

// result channel: one keystream word per item
interface ck4b_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] keystream_word;
   logic [5:0]  word_index;
   logic        last_word;

   modport source (output valid, output keystream_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input keystream_word, input word_index,
                   input last_word, output ready);
endinterface

>>> src/ck4b_qr_unit.sv
// ---------------------------------------------------------------------------
// ck4b_qr_unit
// shared quarter round line: sum = x + y, mixed = rotl(z ^ sum, n(step))
// ---------------------------------------------------------------------------
module ck4b_qr_unit (
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] z,
   input  logic [1:0]  step,
   output logic [31:0] sum,
   output logic [31:0] mixed
);

   logic [31:0] flip;

   assign sum  = x + y;
   assign flip = z ^ sum;

   // rotate amounts 16, 12, 8, 7 for the four lines
   always_comb begin
      case (step)
         2'd0:    mixed = {flip[15:0], flip[31:16]};
         2'd1:    mixed = {flip[19:0], flip[31:20]};
         2'd2:    mixed = {flip[23:0], flip[31:24]};
         2'd3:    mixed = {flip[24:0], flip[31:25]};
         default: mixed = flip;
      endcase
   end

endmodule

>>> src/ck4b_words.sv
// ---------------------------------------------------------------------------
// ck4b_words
// working state of one block: the quarter round unit always works on column
// zero, columns rotate after each quarter round, rows shift for diagonals
// ---------------------------------------------------------------------------
module ck4b_words (
   input  logic                     clock,
   input  ck4b_pkg::ck4b_ctrl_type  ctrl,
   input  ck4b_pkg::ck4b_words_type init_words,
   output ck4b_pkg::ck4b_word_type  head_word
);

   ck4b_pkg::ck4b_words_type words_ff;
   ck4b_pkg::ck4b_words_type words_in;
   ck4b_pkg::ck4b_words_type upd;
   logic [31:0] qr_x, qr_y, qr_z, qr_sum, qr_mixed;

   // move column j+1 into column j, column zero goes to the back
   function automatic ck4b_pkg::ck4b_words_type rot_columns(
      input ck4b_pkg::ck4b_words_type w);
      ck4b_pkg::ck4b_words_type r;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            r[row*4 + col] = w[row*4 + ((col + 1) % 4)];
         end
      end
      return r;
   endfunction

   // rotate row r left by r words
   function automatic ck4b_pkg::ck4b_words_type diagonalize(
      input ck4b_pkg::ck4b_words_type w);
      ck4b_pkg::ck4b_words_type r;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            r[row*4 + col] = w[row*4 + ((col + row) % 4)];
         end
      end
      return r;
   endfunction

   // rotate row r right by r words
   function automatic ck4b_pkg::ck4b_words_type undiagonalize(
      input ck4b_pkg::ck4b_words_type w);
      ck4b_pkg::ck4b_words_type r;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            r[row*4 + col] = w[row*4 + ((col - row + 4) % 4)];
         end
      end
      return r;
   endfunction

   // operand selection: even lines a += b / d mix, odd lines c += d / b mix
   always_comb begin
      if (!ctrl.step[0]) begin
         qr_x = words_ff[0];
         qr_y = words_ff[4];
         qr_z = words_ff[12];
      end else begin
         qr_x = words_ff[8];
         qr_y = words_ff[12];
         qr_z = words_ff[4];
      end
   end

   ck4b_qr_unit u_qr (
      .x     (qr_x),
      .y     (qr_y),
      .z     (qr_z),
      .step  (ctrl.step),
      .sum   (qr_sum),
      .mixed (qr_mixed)
   );

   // write back of one line
   always_comb begin
      upd = words_ff;
      if (!ctrl.step[0]) begin
         upd[0]  = qr_sum;
         upd[12] = qr_mixed;
      end else begin
         upd[8]  = qr_sum;
         upd[4]  = qr_mixed;
      end
   end

   // next working words
   always_comb begin
      words_in = words_ff;
      if (ctrl.load) begin
         words_in = init_words;
      end else if (ctrl.round) begin
         if (ctrl.step == ck4b_pkg::STEP_LAST) begin
            if (ctrl.diag) begin
               words_in = diagonalize(rot_columns(upd));
            end else if (ctrl.undiag) begin
               words_in = undiagonalize(rot_columns(upd));
            end else begin
               words_in = rot_columns(upd);
            end
         end else begin
            words_in = upd;
         end
      end else if (ctrl.shift) begin
         words_in = {words_ff[ck4b_pkg::WORDS_PER_BLOCK-1],
                     words_ff[ck4b_pkg::WORDS_PER_BLOCK-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign head_word = words_ff[0];

endmodule

>>> src/ck4b_ctrl.sv
// ---------------------------------------------------------------------------
// ck4b_ctrl
// sequencer: load block state, run double rounds line by line, stream words
// ---------------------------------------------------------------------------
module ck4b_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [3:0]              doubles,
   input  logic                    out_free,
   output ck4b_pkg::ck4b_ctrl_type ctrl,
   output ck4b_pkg::ck4b_stat_type stat
);

   ck4b_pkg::ck4b_state_type state_ff, state_in;
   logic [1:0]                       step_ff, step_in;
   logic [2:0]                       qr_ff, qr_in;
   logic [3:0]                       dr_ff, dr_in;
   logic [ck4b_pkg::BLK_W-1:0]       blk_ff, blk_in;
   logic [ck4b_pkg::WORD_W-1:0]      word_ff, word_in;

   logic qr_done, dr_done, rounds_done, word_done, blk_last;

   assign qr_done     = (step_ff == ck4b_pkg::STEP_LAST);
   assign dr_done     = qr_done && (qr_ff == ck4b_pkg::QR_DIAG_LAST);
   assign rounds_done = dr_done && (4'(dr_ff + 4'd1) == doubles);
   assign word_done   = (word_ff == ck4b_pkg::WORD_LAST);
   assign blk_last    = (blk_ff == ck4b_pkg::BLK_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ck4b_pkg::ST_IDLE: begin
            if (start) state_in = ck4b_pkg::ST_INIT;
         end
         ck4b_pkg::ST_INIT: begin
            state_in = (doubles == 4'd0) ? ck4b_pkg::ST_OUT : ck4b_pkg::ST_ROUND;
         end
         ck4b_pkg::ST_ROUND: begin
            if (rounds_done) state_in = ck4b_pkg::ST_OUT;
         end
         ck4b_pkg::ST_OUT: begin
            if (out_free && word_done) begin
               state_in = blk_last ? ck4b_pkg::ST_IDLE : ck4b_pkg::ST_INIT;
            end
         end
         default: state_in = ck4b_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl       = '0;
      stat       = '0;
      ctrl.step  = step_ff;
      stat.blk   = blk_ff;
      stat.word  = word_ff;
      stat.last  = blk_last && word_done;
      case (state_ff)
         ck4b_pkg::ST_IDLE: begin
            stat.ready = 1'b1;
         end
         ck4b_pkg::ST_INIT: begin
            ctrl.load = 1'b1;
         end
         ck4b_pkg::ST_ROUND: begin
            ctrl.round  = 1'b1;
            ctrl.diag   = qr_ff == ck4b_pkg::QR_COL_LAST;
            ctrl.undiag = qr_ff == ck4b_pkg::QR_DIAG_LAST;
         end
         ck4b_pkg::ST_OUT: begin
            ctrl.shift = out_free;
            stat.emit  = out_free;
         end
         default: begin
            stat.ready = 1'b0;
         end
      endcase
   end

   // loop counters
   always_comb begin
      step_in = 2'd0;
      qr_in   = qr_ff;
      dr_in   = dr_ff;
      word_in = word_ff;
      blk_in  = blk_ff;
      if (state_ff == ck4b_pkg::ST_IDLE) begin
         blk_in = '0;
      end
      if (state_ff == ck4b_pkg::ST_INIT) begin
         qr_in   = 3'd0;
         dr_in   = 4'd0;
         word_in = '0;
      end
      if (state_ff == ck4b_pkg::ST_ROUND) begin
         step_in = 2'(step_ff + 2'd1);
         if (qr_done) qr_in = 3'(qr_ff + 3'd1);
         if (dr_done) dr_in = 4'(dr_ff + 4'd1);
      end
      if (state_ff == ck4b_pkg::ST_OUT && out_free) begin
         word_in = ck4b_pkg::WORD_W'(word_ff + 1'b1);
         if (word_done) blk_in = ck4b_pkg::BLK_W'(blk_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ck4b_pkg::ST_IDLE;
         step_ff  <= '0;
         qr_ff    <= '0;
         dr_ff    <= '0;
         blk_ff   <= '0;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         qr_ff    <= qr_in;
         dr_ff    <= dr_in;
         blk_ff   <= blk_in;
         word_ff  <= word_in;
      end
   end

endmodule

>>> src/chacha_keystream_four_blocks_unit.sv
// ---------------------------------------------------------------------------
// chacha_keystream_four_blocks_unit
// chacha keystream generator, four 64-byte blocks per generate item
// ---------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req_chan  in   valid / ready    command, counter_value
//  rsp_chan  out  valid / ready    keystream_word, word_index, last_word
//  csr_*     in   csr_wr_en only   csr_index, csr_wr_data
//
//  load item: taken without leaving idle, no result.
//  generate item: per block the state is loaded, the double rounds run and 16
//  words stream out; the shared quarter round unit does one add-xor-rotate line
//  per cycle; ready again after the last word is registered.
//  rsp stalls hold the word stream; synchronous reset clears config (round
//  count to 20), counter and sequencer, no clearing pass.
// ---------------------------------------------------------------------------
`include "chacha_keystream_four_blocks_unit_assert.svh"

module chacha_keystream_four_blocks_unit (
   input  logic        clock,
   input  logic        reset,
   ck4b_req_if.sink    req_chan,
   ck4b_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   logic [63:0] sigma_low_ff, sigma_high_ff;
   logic [63:0] key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic [63:0] nonce_ff;
   logic [4:0]  round_count_ff;

   logic [63:0] block_counter_ff, block_counter_in;
   logic [63:0] blk_ctr_ff, blk_ctr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff;
   logic [5:0]  rsp_index_ff;
   logic        rsp_last_ff;

   logic                     start, out_free;
   ck4b_pkg::ck4b_ctrl_type  ctrl;
   ck4b_pkg::ck4b_stat_type  stat;
   ck4b_pkg::ck4b_words_type init_words;
   ck4b_pkg::ck4b_word_type  head_word;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_low_ff   <= '0;
         sigma_high_ff  <= '0;
         key_a_ff       <= '0;
         key_b_ff       <= '0;
         key_c_ff       <= '0;
         key_d_ff       <= '0;
         nonce_ff       <= '0;
         round_count_ff <= ck4b_pkg::ROUND_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (ck4b_pkg::ck4b_reg_type'(csr_index))
            ck4b_pkg::REG_SIGMA_LOW:   sigma_low_ff   <= csr_wr_data;
            ck4b_pkg::REG_SIGMA_HIGH:  sigma_high_ff  <= csr_wr_data;
            ck4b_pkg::REG_KEY_PART_A:  key_a_ff       <= csr_wr_data;
            ck4b_pkg::REG_KEY_PART_B:  key_b_ff       <= csr_wr_data;
            ck4b_pkg::REG_KEY_PART_C:  key_c_ff       <= csr_wr_data;
            ck4b_pkg::REG_KEY_PART_D:  key_d_ff       <= csr_wr_data;
            ck4b_pkg::REG_NONCE_WORDS: nonce_ff       <= csr_wr_data;
            ck4b_pkg::REG_ROUND_COUNT: round_count_ff <= csr_wr_data[4:0];
            default:                   round_count_ff <= round_count_ff;
         endcase
      end
   end

   // request handshake
   assign req_chan.ready = stat.ready;
   assign start = req_chan.valid && stat.ready && (req_chan.command == ck4b_pkg::CMD_GEN);

   // stored counter and counter of the block in work
   always_comb begin
      block_counter_in = block_counter_ff;
      blk_ctr_in       = blk_ctr_ff;
      if (req_chan.valid && stat.ready) begin
         if (req_chan.command == ck4b_pkg::CMD_LOAD) begin
            block_counter_in = req_chan.counter_value;
         end else begin
            blk_ctr_in = block_counter_ff;
         end
      end
      if (stat.emit && stat.word == ck4b_pkg::WORD_LAST) begin
         blk_ctr_in = blk_ctr_ff + 64'd1;
         if (stat.last) block_counter_in = blk_ctr_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_counter_ff <= '0;
         blk_ctr_ff       <= '0;
      end else begin
         block_counter_ff <= block_counter_in;
         blk_ctr_ff       <= blk_ctr_in;
      end
   end

   // block input state, word 0 in the low bits
   assign init_words = {nonce_ff, blk_ctr_ff, key_d_ff, key_c_ff,
                        key_b_ff, key_a_ff, sigma_high_ff, sigma_low_ff};

   ck4b_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .doubles  (round_count_ff[4:1]),
      .out_free (out_free),
      .ctrl     (ctrl),
      .stat     (stat)
   );

   ck4b_words u_words (
      .clock      (clock),
      .ctrl       (ctrl),
      .init_words (init_words),
      .head_word  (head_word)
   );

   // output register with feed-forward add
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.emit) begin
         rsp_word_ff  <= head_word + init_words[stat.word];
         rsp_index_ff <= ck4b_pkg::INDEX_W'({stat.blk, stat.word});
         rsp_last_ff  <= stat.last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.keystream_word = rsp_word_ff;
   assign rsp_chan.word_index     = rsp_index_ff;
   assign rsp_chan.last_word      = rsp_last_ff;

   // checks
   `CK4B_ASSERT_ALWAYS(a_no_overrun, !stat.emit || !rsp_valid_ff || rsp_chan.ready, "word register overwritten")
   `CK4B_ASSERT_NEXT(a_gen_busy, start, !req_chan.ready, "generate item did not make the unit busy")
   `CK4B_ASSERT_NEXT(a_last_idle, stat.emit && stat.last, req_chan.ready, "not ready after last word")
   `CK4B_ASSERT_ALWAYS(a_last_index, !rsp_valid_ff || !rsp_last_ff || (rsp_index_ff == ck4b_pkg::INDEX_LAST), "last word with wrong index")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// testbench of the chacha four block keystream unit: directed and random
// request items, bursty sender, stalling receiver, each keystream item
// checked against a block function computed here from shadow registers
// ---------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD     = 8;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_PHASES  = 17;
   localparam int PHASE_ITEMS    = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [31:0] word;
      logic [5:0]  index;
      logic        last;
   } keystream_item_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_BURSTY
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wr_data;

   ck4b_req_if req_if ();
   ck4b_rsp_if rsp_if ();

   // shadow of the block: registers, block counter and pending keystream
   logic [63:0]        cfg_shadow [8];
   logic [4:0]         rounds_shadow;
   logic [63:0]        ctr_shadow;
   keystream_item_type expected_words [$];

   int mismatch_count = 0;
   int burst_left     = 0;

   chacha_keystream_four_blocks_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // keystream block function
   // ------------------------------------------------------------------
   function automatic logic [31:0] rotl32(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic ck4b_pkg::ck4b_words_type quarter_round(
      ck4b_pkg::ck4b_words_type w, int a, int b, int c, int d);
      w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
      w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
      w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
      w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
      return w;
   endfunction

   // expected 64 words of one generate item, then counter advance
   function automatic void predict_keystream_request();
      ck4b_pkg::ck4b_words_type start_words;
      ck4b_pkg::ck4b_words_type mix;
      logic [63:0]              blk_ctr;
      keystream_item_type       item;
      int                       doubles;
      doubles = int'(rounds_shadow) >> 1;
      for (int k = 0; k < ck4b_pkg::BLOCKS_PER_REQUEST; k++) begin
         blk_ctr = ctr_shadow + 64'(k);
         // constants and key: register p holds state words 2p and 2p+1
         for (int p = 0; p < 6; p++) begin
            start_words[2*p]   = cfg_shadow[p][31:0];
            start_words[2*p+1] = cfg_shadow[p][63:32];
         end
         start_words[12] = blk_ctr[31:0];
         start_words[13] = blk_ctr[63:32];
         start_words[14] = cfg_shadow[ck4b_pkg::REG_NONCE_WORDS][31:0];
         start_words[15] = cfg_shadow[ck4b_pkg::REG_NONCE_WORDS][63:32];
         mix = start_words;
         for (int dr = 0; dr < doubles; dr++) begin
            // column round
            mix = quarter_round(mix, 0, 4, 8, 12);
            mix = quarter_round(mix, 1, 5, 9, 13);
            mix = quarter_round(mix, 2, 6, 10, 14);
            mix = quarter_round(mix, 3, 7, 11, 15);
            // diagonal round
            mix = quarter_round(mix, 0, 5, 10, 15);
            mix = quarter_round(mix, 1, 6, 11, 12);
            mix = quarter_round(mix, 2, 7, 8, 13);
            mix = quarter_round(mix, 3, 4, 9, 14);
         end
         // feed-forward and stream out
         for (int i = 0; i < ck4b_pkg::WORDS_PER_BLOCK; i++) begin
            item.word  = mix[i] + start_words[i];
            item.index = ck4b_pkg::INDEX_W'(k * ck4b_pkg::WORDS_PER_BLOCK + i);
            item.last  = (item.index == ck4b_pkg::INDEX_LAST);
            expected_words.push_back(item);
         end
      end
      ctr_shadow = ctr_shadow + 64'(ck4b_pkg::BLOCKS_PER_REQUEST);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------
   // one request item; entered and left just after a falling edge
   task automatic send_item(input logic cmd, input logic [63:0] ctr_value);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_if.command       <= cmd;
      req_if.counter_value <= ctr_value;
      req_if.valid         <= 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (cmd == ck4b_pkg::CMD_LOAD)
         ctr_shadow = ctr_value;
      else
         predict_keystream_request();
      burst_left--;
      @(negedge clock);
      if (burst_left == 0)
         req_if.valid <= 1'b0;
   endtask

   // end the current burst early
   task automatic stop_sending();
      if (burst_left != 0) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   task automatic csr_write(input ck4b_pkg::ck4b_reg_type reg_idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= reg_idx;
      csr_wr_data <= data;
      if (reg_idx == ck4b_pkg::REG_ROUND_COUNT)
         rounds_shadow = data[4:0];
      else
         cfg_shadow[reg_idx] = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // drain all keystream items, then let a load settle
   task automatic wait_idle();
      stop_sending();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rounds(input logic [4:0] rounds);
      csr_write(ck4b_pkg::REG_ROUND_COUNT, {rand64()} & ~64'h1f | 64'(rounds));
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // registers and counter straight out of reset
   task automatic test_reset_defaults();
      send_item(ck4b_pkg::CMD_GEN, rand64());
   endtask

   // standard constants, sequential key, counter loaded then advanced
   task automatic test_known_vector();
      wait_idle();
      csr_write(ck4b_pkg::REG_SIGMA_LOW,   64'h3320646e_61707865);
      csr_write(ck4b_pkg::REG_SIGMA_HIGH,  64'h6b206574_79622d32);
      csr_write(ck4b_pkg::REG_KEY_PART_A,  64'h07060504_03020100);
      csr_write(ck4b_pkg::REG_KEY_PART_B,  64'h0f0e0d0c_0b0a0908);
      csr_write(ck4b_pkg::REG_KEY_PART_C,  64'h17161514_13121110);
      csr_write(ck4b_pkg::REG_KEY_PART_D,  64'h1f1e1d1c_1b1a1918);
      csr_write(ck4b_pkg::REG_NONCE_WORDS, 64'h4a000000_09000000);
      write_rounds(5'd20);
      send_item(ck4b_pkg::CMD_LOAD, 64'd1);
      send_item(ck4b_pkg::CMD_GEN, rand64());
      send_item(ck4b_pkg::CMD_GEN, rand64());
   endtask

   // zero, odd, even, and above twenty rounds
   task automatic test_round_counts();
      logic [4:0] rounds_list [6] = '{5'd0, 5'd1, 5'd2, 5'd7, 5'd12, 5'd31};
      foreach (rounds_list[r]) begin
         wait_idle();
         write_rounds(rounds_list[r]);
         send_item(ck4b_pkg::CMD_GEN, rand64());
      end
   endtask

   // carry into word 13 within a request, and 64-bit wrap
   task automatic test_counter_carry();
      wait_idle();
      write_rounds(5'd8);
      send_item(ck4b_pkg::CMD_LOAD, 64'h00000000_fffffffe);
      send_item(ck4b_pkg::CMD_GEN, rand64());
      send_item(ck4b_pkg::CMD_LOAD, 64'hffffffff_fffffffe);
      send_item(ck4b_pkg::CMD_GEN, rand64());
      send_item(ck4b_pkg::CMD_GEN, rand64());
      // back to back loads, the second one wins
      send_item(ck4b_pkg::CMD_LOAD, 64'hffffffff_ffffffff);
      send_item(ck4b_pkg::CMD_LOAD, 64'h0);
      send_item(ck4b_pkg::CMD_GEN, 64'hffffffff_ffffffff);
   endtask

   // every register all ones, then all zeros
   task automatic test_config_extremes();
      wait_idle();
      for (int r = 0; r < 8; r++)
         csr_write(ck4b_pkg::ck4b_reg_type'(r), 64'hffffffff_ffffffff);
      send_item(ck4b_pkg::CMD_GEN, rand64());
      wait_idle();
      for (int r = 0; r < 8; r++)
         csr_write(ck4b_pkg::ck4b_reg_type'(r), 64'h0);
      send_item(ck4b_pkg::CMD_GEN, rand64());
   endtask

   // random phases of generate and load items under random settings
   task automatic test_random_traffic();
      logic [63:0] data;
      int          pick;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         for (int r = 0; r < 7; r++) begin
            if (ph == 0 || $urandom_range(0, 1) == 0) begin
               pick = $urandom_range(0, 9);
               data = (pick == 0) ? 64'h0 :
                      (pick == 1) ? 64'hffffffff_ffffffff : rand64();
               csr_write(ck4b_pkg::ck4b_reg_type'(r), data);
            end
         end
         // mostly few rounds to keep the run short
         pick = $urandom_range(0, 9);
         if (pick < 7)
            write_rounds(5'($urandom_range(0, 8)));
         else if (pick < 9)
            write_rounds(5'($urandom_range(9, 20)));
         else
            write_rounds(5'($urandom_range(21, 31)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 3) != 0) begin
               send_item(ck4b_pkg::CMD_GEN, rand64());
            end else begin
               pick = $urandom_range(0, 3);
               if (pick < 2)
                  send_item(ck4b_pkg::CMD_LOAD, rand64());
               else if (pick == 2)
                  send_item(ck4b_pkg::CMD_LOAD,
                            {$urandom, 28'hfffffff, 4'($urandom)});
               else
                  send_item(ck4b_pkg::CMD_LOAD,
                            64'hffffffff_fffffff0 | 64'($urandom_range(0, 15)));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // receiver stall pattern
   // ------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      stall_mode_type stall_mode;
      int             mode_left;
      int             hold_left;
      logic           hold_level;
      int             cycle_cnt;
      rsp_if.ready = 1'b0;
      stall_mode   = STALL_NONE;
      mode_left    = 0;
      hold_left    = 0;
      hold_level   = 1'b1;
      cycle_cnt    = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(64, 400);
         end
         mode_left--;
         cycle_cnt++;
         case (stall_mode)
            STALL_NONE: begin
               rsp_if.ready <= 1'b1;
            end
            STALL_RANDOM: begin
               rsp_if.ready <= ($urandom_range(0, 3) != 0);
            end
            STALL_PERIODIC: begin
               rsp_if.ready <= (cycle_cnt % 4 != 0);
            end
            default: begin
               if (hold_left == 0) begin
                  hold_level = ~hold_level;
                  hold_left  = hold_level ? $urandom_range(1, 16) : $urandom_range(1, 8);
               end
               hold_left--;
               rsp_if.ready <= hold_level;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // keystream checker
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin : keystream_checker
      keystream_item_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected item: word %h index %0d last %b",
                            rsp_if.keystream_word, rsp_if.word_index, rsp_if.last_word));
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.keystream_word !== want.word || rsp_if.word_index !== want.index ||
                rsp_if.last_word !== want.last)
               report_mismatch($sformatf(
                  "item mismatch: expected word %h index %0d last %b, got word %h index %0d last %b",
                  want.word, want.index, want.last,
                  rsp_if.keystream_word, rsp_if.word_index, rsp_if.last_word));
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.command       = ck4b_pkg::CMD_GEN;
      req_if.counter_value = 64'h0;
      csr_wr_en            = 1'b0;
      csr_index            = ck4b_pkg::REG_SIGMA_LOW;
      csr_wr_data          = 64'h0;
      foreach (cfg_shadow[r]) cfg_shadow[r] = 64'h0;
      rounds_shadow = ck4b_pkg::ROUND_COUNT_RESET;
      ctr_shadow    = 64'h0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_known_vector();
      test_round_counts();
      test_counter_carry();
      test_config_extremes();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("chacha_keystream_four_blocks_unit verification clean");
      else
         $display("chacha_keystream_four_blocks_unit verification failed");
      $finish;
   end

   // run limit
   initial begin
      #(50_000_000);
      $display("chacha_keystream_four_blocks_unit verification failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/ck4b_pkg.sv
src/ck4b_if.sv
src/ck4b_qr_unit.sv
src/ck4b_words.sv
src/ck4b_ctrl.sv
src/chacha_keystream_four_blocks_unit.sv
tb/tb_top.sv
